FILE: design/olt_pkg.sv
`default_nettype none

package olt_pkg;

    // Default number of table entries
    localparam int CAPACITY_DEF = 16;

    // Action codes
    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_DELETE  = 2'd1;
    localparam logic [1:0] ACT_REVERSE = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    // Command beat
    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [3:0]         index;
    } olt_cmd_t;

    // Response beat
    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
        logic [4:0]         entry_count;
        logic               overflow;
    } olt_rsp_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic               ins;
        logic               del;
        logic               rev;
        logic               front;
        logic signed [31:0] value;
    } olt_ctl_t;

    // Compare status from a cell
    typedef struct packed {
        logic gt;
        logic gt_last;
    } olt_stat_t;

endpackage

`default_nettype wire

FILE: design/olt_cell.sv
`default_nettype none

module olt_cell
    import olt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int OCC_W = 5
)
(
    input  wire logic               clk,
    input  wire olt_ctl_t           ctl,
    input  wire logic [OCC_W-1:0]   occ,
    input  wire logic signed [31:0] lower_data,
    input  wire logic signed [31:0] upper_data,
    input  wire logic               lower_shift,
    input  wire logic               lo_in,
    input  wire logic               hi_in,
    output logic signed [31:0]      data,
    output logic                    shift,
    output logic                    lo_out,
    output logic                    hi_out,
    output olt_stat_t               stat
);

    localparam logic [OCC_W-1:0] POS       = OCC_W'(IDX);
    localparam logic [OCC_W-1:0] POS_NEXT  = OCC_W'(IDX + 1);
    localparam bit               NOT_FIRST = (IDX != 0);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               data_en;
    logic               valid;
    logic               below_last;
    logic               ge;
    logic               gt;
    logic               eq;
    logic               term;
    logic               del_here;

    assign valid      = POS < occ;
    assign below_last = POS_NEXT < occ;
    assign ge         = !(data_reg < ctl.value);
    assign gt         = ctl.value < data_reg;
    assign eq         = valid && (data_reg == ctl.value);

    // Term carried along both chains: match for delete, stop point for insert
    always_comb
    begin
        if (ctl.del)
            term = eq;
        else if (ctl.rev)
            term = ge && below_last;
        else
            term = ge && valid && NOT_FIRST;
    end

    assign lo_out = lo_in | term;
    assign hi_out = hi_in | term;

    // At or above the insert point
    always_comb
    begin
        if (ctl.rev)
            shift = ctl.front ? !valid : !hi_out;
        else
            shift = ctl.front || !valid || lo_out;
    end

    // At or above the removed entry
    assign del_here = ctl.rev ? (lo_out && !hi_in) : lo_out;

    always_comb
    begin
        data_en   = 1'b0;
        data_next = data_reg;
        if (ctl.ins && shift)
        begin
            data_en   = 1'b1;
            data_next = lower_shift ? lower_data : ctl.value;
        end
        else if (ctl.del && del_here)
        begin
            data_en   = 1'b1;
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_en)
            data_reg <= data_next;
    end

    assign data         = data_reg;
    assign stat.gt      = gt;
    assign stat.gt_last = gt && (POS_NEXT == occ);

endmodule

`default_nettype wire

FILE: design/ordered_list_table_top.sv
// Ordered table of signed 32-bit values, one action per command beat.
// Command channel (cmd, cmd_valid, cmd_stall): action insert, delete, reverse
// or read, with a value and a read index. Response channel (rsp, rsp_valid,
// rsp_stall): exactly one beat per command, carrying found, read_value,
// entry_count and overflow.
// For each command the beat is first accepted, then every cell
// compares its entry with the value in parallel, the insert or delete point
// ripples along the cell chain, and the cells shift in one step while the
// response is registered. A new command is taken only after the one in
// flight has retired.
// Reverse only flips an order flag; the cells keep their physical layout
// and insert, delete and read interpret positions through that flag.
// Reset empties the table at once (occupancy zero, flag clear); entry
// storage is not cleared, since only entries below the occupancy are read.
// When the receiver stalls, the response is held in its register and the
// next command waits in the command register until the response leaves.
`default_nettype none

module ordered_list_table_top
    import olt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire olt_cmd_t cmd,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    output olt_rsp_t      rsp,
    output logic          rsp_valid,
    input  wire logic     rsp_stall
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int RD_W  = (OCC_W > 4) ? OCC_W : 4;
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

    olt_cmd_t         cmd_reg;
    logic             busy_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             rev_reg;
    olt_rsp_t         rsp_reg;
    olt_rsp_t         rsp_next;
    logic             rsp_valid_reg;

    logic             accept;
    logic             finish;
    logic             full;
    logic             found;
    olt_ctl_t         ctl;

    logic signed [31:0] cell_data [CAPACITY];
    olt_stat_t          cell_stat [CAPACITY];
    logic [CAPACITY-1:0] gt_last_vec;
    logic [CAPACITY:0]   lo_chain;
    logic [CAPACITY:0]   hi_chain;
    logic [CAPACITY:0]   shift_chain;

    logic [RD_W-1:0]     idx_ext;
    logic [RD_W-1:0]     occ_ext;
    logic [RD_W-1:0]     phys_idx;
    logic                in_range;
    logic signed [31:0]  rd_data;

    // Handshake: one command in flight, retire when the response slot frees
    assign cmd_stall = busy_reg;
    assign accept    = cmd_valid && !busy_reg;
    assign finish    = busy_reg && (!rsp_valid_reg || !rsp_stall);

    assign full  = (occ_reg == OCC_FULL);
    assign found = lo_chain[CAPACITY];

    // Broadcast control; cells change only on the retiring cycle
    assign ctl.ins   = finish && (cmd_reg.action == ACT_INSERT) && !full;
    assign ctl.del   = finish && (cmd_reg.action == ACT_DELETE);
    assign ctl.rev   = rev_reg;
    assign ctl.value = cmd_reg.value;
    assign ctl.front = (occ_reg == '0) || (rev_reg ? (|gt_last_vec) : cell_stat[0].gt);

    assign lo_chain[0]           = 1'b0;
    assign hi_chain[CAPACITY]    = 1'b0;
    assign shift_chain[0]        = 1'b0;

    // Cell chain: each cell holds one entry, trades data with its neighbours
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] lower_data;
        logic signed [31:0] upper_data;

        if (g == 0)
        begin : g_lo_end
            assign lower_data = '0;
        end
        else
        begin : g_lo_mid
            assign lower_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_hi_end
            assign upper_data = cell_data[g];
        end
        else
        begin : g_hi_mid
            assign upper_data = cell_data[g+1];
        end

        olt_cell #(
            .IDX   (g),
            .OCC_W (OCC_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occ         (occ_reg),
            .lower_data  (lower_data),
            .upper_data  (upper_data),
            .lower_shift (shift_chain[g]),
            .lo_in       (lo_chain[g]),
            .hi_in       (hi_chain[g+1]),
            .data        (cell_data[g]),
            .shift       (shift_chain[g+1]),
            .lo_out      (lo_chain[g+1]),
            .hi_out      (hi_chain[g]),
            .stat        (cell_stat[g])
        );

        assign gt_last_vec[g] = cell_stat[g].gt_last;
    end

    // Read: map the logical index through the order flag
    assign idx_ext  = RD_W'(cmd_reg.index);
    assign occ_ext  = RD_W'(occ_reg);
    assign in_range = idx_ext < occ_ext;
    assign phys_idx = rev_reg ? (occ_ext - idx_ext - RD_W'(1)) : idx_ext;
    assign rd_data  = cell_data[phys_idx[IDX_W-1:0]];

    always_comb
    begin
        occ_next = occ_reg;
        rsp_next = '0;
        unique case (cmd_reg.action)
            ACT_INSERT:
            begin
                if (full)
                    rsp_next.overflow = 1'b1;
                else
                    occ_next = occ_reg + OCC_W'(1);
            end
            ACT_DELETE:
            begin
                rsp_next.found = found;
                if (found)
                    occ_next = occ_reg - OCC_W'(1);
            end
            ACT_REVERSE:
            begin
                occ_next = occ_reg;
            end
            ACT_READ:
            begin
                rsp_next.found      = in_range;
                rsp_next.read_value = in_range ? rd_data : '0;
            end
        endcase
        rsp_next.entry_count = 5'(occ_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            occ_reg       <= '0;
            rev_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (finish)
                busy_reg <= 1'b0;

            if (finish)
            begin
                occ_reg <= occ_next;
                if (cmd_reg.action == ACT_REVERSE)
                    rev_reg <= !rev_reg;
            end

            if (finish)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers: hold the command and response beats
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
        if (finish)
            rsp_reg <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Occupancy never passes the number of cells
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("occupancy above capacity");

    // An accepted command is in flight on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted command lost");

    // A retiring command presents its response on the next cycle
    a_finish_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> rsp_valid)
        else $error("response not presented");

    // An insert into a non-full table always opens a slot at the top cell
    a_ins_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |-> shift_chain[CAPACITY])
        else $error("insert would push an entry off the chain");

    // Both match chains agree on whether a delete hit
    a_del_chains: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.del |-> (lo_chain[CAPACITY] == hi_chain[0]))
        else $error("delete match chains disagree");

endmodule

`default_nettype wire
